@@ hw/rtl/pmfs_pkg.sv @@
// Shared types and constants of the particle motion and fade step block.
`default_nettype none

package pmfs_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned MPL_W   = 16;
  localparam int unsigned PROD_W  = WORD_W + MPL_W;
  localparam int unsigned QUOT_W  = 38;
  localparam int unsigned REM_W   = 10;
  localparam int unsigned DVS_W   = REM_W + 1;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MPL_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

  localparam logic [DVS_W-1:0] MS_PER_S    = DVS_W'(1000);
  localparam logic [DVS_W-1:0] FADE_IN_MS  = DVS_W'(200);
  localparam logic [DVS_W-1:0] FADE_OUT_MS = DVS_W'(1000);

  localparam logic [15:0] BOUNCE_GAIN_RST = 16'd58982;
  localparam logic [15:0] LIFE_TOTAL_RST  = 16'd1000;
  localparam logic [7:0]  BASE_ALPHA_RST  = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNCE_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIFE_TOTAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_ALPHA  = 3'd5;

  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic {
    DIV_MS,
    DIV_FADE_IN
  } pmfs_div_e;

  typedef struct packed {
    logic [WORD_W-1:0] mag;
    logic [MPL_W-1:0]  mplier;
    logic              div_en;
    pmfs_div_e         div_sel;
  } pmfs_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/pmfs_if.sv @@
// Valid/ready channel interfaces for input items and result beats.
`default_nettype none

interface pmfs_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic        [31:0] time_ms;
  logic signed [31:0] start_pos_x;
  logic signed [31:0] start_pos_y;
  logic signed [31:0] start_pos_z;
  logic signed [31:0] start_vel_x;
  logic signed [31:0] start_vel_y;
  logic signed [31:0] start_vel_z;

  modport source (
    output valid, kind, time_ms, start_pos_x, start_pos_y, start_pos_z,
    output start_vel_x, start_vel_y, start_vel_z,
    input  ready
  );
  modport sink (
    input  valid, kind, time_ms, start_pos_x, start_pos_y, start_pos_z,
    input  start_vel_x, start_vel_y, start_vel_z,
    output ready
  );
endinterface

interface pmfs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [7:0]  alpha;
  logic               alive;

  modport source (
    output valid, pos_x, pos_y, pos_z, alpha, alive,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, alpha, alive,
    output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/pmfs_muldiv.sv @@
// Bit-serial unsigned multiplier followed by an optional restoring divide by a small constant.
`default_nettype none

module pmfs_muldiv
  import pmfs_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire pmfs_cmd_t         cmd_i,
  output logic                   done_o,
  output logic [PROD_W-1:0]      res_o
);

  typedef enum logic [1:0] {
    U_IDLE,
    U_MUL,
    U_DIV,
    U_DONE
  } u_state_e;

  u_state_e          state_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [PROD_W-1:0] acc_q;
  logic [WORD_W-1:0] mag_q;
  logic [MPL_W-1:0]  mpl_q;
  logic              div_en_q;
  pmfs_div_e         div_sel_q;
  logic [REM_W-1:0]  rem_q;

  logic [WORD_W:0]   mul_sum;
  logic [DVS_W-1:0]  divisor;
  logic [DVS_W-1:0]  trial;
  logic [DVS_W-1:0]  diff;
  logic              fits;

  assign mul_sum = {1'b0, acc_q[PROD_W-1:MPL_W]} + (mpl_q[0] ? {1'b0, mag_q} : '0);
  assign divisor = (div_sel_q == DIV_FADE_IN) ? FADE_IN_MS : MS_PER_S;
  assign trial   = {rem_q, acc_q[PROD_W-1]};
  assign fits    = (trial >= divisor);
  assign diff    = trial - divisor;

  assign done_o = (state_q == U_DONE);
  assign res_o  = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= U_IDLE;
      cnt_q     <= '0;
      acc_q     <= '0;
      mag_q     <= '0;
      mpl_q     <= '0;
      div_en_q  <= 1'b0;
      div_sel_q <= DIV_MS;
      rem_q     <= '0;
    end else begin
      unique case (state_q)
        U_IDLE: begin
          if (start_i) begin
            mag_q     <= cmd_i.mag;
            mpl_q     <= cmd_i.mplier;
            div_en_q  <= cmd_i.div_en;
            div_sel_q <= cmd_i.div_sel;
            acc_q     <= '0;
            rem_q     <= '0;
            cnt_q     <= '0;
            state_q   <= U_MUL;
          end
        end
        U_MUL: begin
          acc_q <= {mul_sum, acc_q[MPL_W-1:1]};
          mpl_q <= {1'b0, mpl_q[MPL_W-1:1]};
          if (cnt_q == MUL_LAST) begin
            cnt_q   <= '0;
            state_q <= div_en_q ? U_DIV : U_DONE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        U_DIV: begin
          rem_q <= fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
          acc_q <= {acc_q[PROD_W-2:0], fits};
          if (cnt_q == DIV_LAST) begin
            cnt_q   <= '0;
            state_q <= U_DONE;
          end else begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
        U_DONE: begin
          state_q <= U_IDLE;
        end
        default: begin
          state_q <= U_IDLE;
        end
      endcase
    end
  end

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == U_IDLE)
    else $error("muldiv started while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("muldiv done held for more than one cycle");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == U_DIV |-> {1'b0, rem_q} < divisor)
    else $error("division remainder out of range");

endmodule

`default_nettype wire

@@ hw/rtl/particle_motion_fade_step_top.sv @@
// Top level of the particle motion and fade step block.
// One particle in Q16.16: a spawn beat loads position and velocity and goes straight
// to the result stage, as does a tick on a dead particle. A live tick runs one velocity
// and one position update per axis, then an optional ground bounce and an optional fade,
// all through one shared bit-serial unit: a multiply-and-divide is a launch, the 16-bit
// multiply, one bit of elapsed time or gain per cycle, the divide of the 48-bit product
// by 1000 or 200, one quotient bit per cycle, and a handoff; a bounce scaling skips the
// divide. One item is in work at a time; the result register lets a new item enter
// while the previous result beat still waits.
`default_nettype none

module particle_motion_fade_step_top
  import pmfs_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,
  pmfs_in_if.sink                   item_i,
  pmfs_out_if.source                result_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_VEL,
    S_POS,
    S_BNC,
    S_FADE,
    S_ALPHA,
    S_LIFE,
    S_FIN
  } state_e;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  function automatic logic [WORD_W-1:0] mag_of(input logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_add(
    input logic signed [WORD_W-1:0] base,
    input logic [QUOT_W-1:0]        mag,
    input logic                     neg
  );
    logic [39:0] ext;
    logic [39:0] del;
    logic [39:0] sum;
    ext = {{8{base[WORD_W-1]}}, base};
    del = neg ? (40'd0 - {2'b00, mag}) : {2'b00, mag};
    sum = ext + del;
    if (!sum[39] && (|sum[38:31])) begin
      return 32'sh7FFF_FFFF;
    end else if (sum[39] && !(&sum[38:31])) begin
      return 32'sh8000_0000;
    end
    return $signed(sum[31:0]);
  endfunction

  logic signed [WORD_W-1:0] accel_q [3];
  logic [15:0]              bounce_gain_q;
  logic [15:0]              life_total_q;
  logic [7:0]               base_alpha_q;

  state_e                   state_q;
  logic signed [WORD_W-1:0] pos_q [3];
  logic signed [WORD_W-1:0] vel_q [3];
  logic [15:0]              life_left_q;
  logic                     alive_q;
  logic [WORD_W-1:0]        last_time_q;
  logic                     first_tick_q;
  logic [MPL_W-1:0]         dt_q;
  logic [WORD_W-1:0]        now_q;
  logic [7:0]               alpha_q;
  logic [1:0]               ax_q;
  logic                     launched_q;

  logic                     out_vld_q;
  logic signed [WORD_W-1:0] out_pos_x_q;
  logic signed [WORD_W-1:0] out_pos_y_q;
  logic signed [WORD_W-1:0] out_pos_z_q;
  logic [7:0]               out_alpha_q;
  logic                     out_alive_q;

  pmfs_cmd_t                mdu_cmd;
  logic                     mdu_start;
  logic                     mdu_done;
  logic [PROD_W-1:0]        mdu_res;
  logic [QUOT_W-1:0]        quot;
  logic [WORD_W-1:0]        kept;

  logic [WORD_W-1:0]        time_diff;
  logic [MPL_W-1:0]         dt_in;
  logic [16:0]              used;
  logic                     used_neg;
  logic                     fade_in;
  logic                     fade_out;
  logic [15:0]              life_next;

  assign time_diff = item_i.time_ms - last_time_q;
  assign dt_in     = first_tick_q ? '0 :
                     ((|time_diff[WORD_W-1:MPL_W]) ? '1 : time_diff[MPL_W-1:0]);

  assign used      = {1'b0, life_total_q} - {1'b0, life_left_q};
  assign used_neg  = used[16];
  assign fade_in   = !used_neg && (used[15:0] < 16'(FADE_IN_MS));
  assign fade_out  = (life_left_q < 16'(FADE_OUT_MS));
  assign life_next = (life_left_q > dt_q) ? (life_left_q - dt_q) : '0;

  assign quot = mdu_res[QUOT_W-1:0];
  assign kept = mdu_res[PROD_W-1:MPL_W];

  assign mdu_start = !launched_q &&
                     (state_q == S_VEL || state_q == S_POS ||
                      state_q == S_BNC || state_q == S_ALPHA);

  always_comb begin
    mdu_cmd = '{mag: '0, mplier: '0, div_en: 1'b0, div_sel: DIV_MS};
    case (state_q)
      S_VEL: begin
        mdu_cmd.mag    = mag_of(accel_q[ax_q]);
        mdu_cmd.mplier = dt_q;
        mdu_cmd.div_en = 1'b1;
      end
      S_POS: begin
        mdu_cmd.mag    = mag_of(vel_q[ax_q]);
        mdu_cmd.mplier = dt_q;
        mdu_cmd.div_en = 1'b1;
      end
      S_BNC: begin
        mdu_cmd.mag    = mag_of(vel_q[AX_Y]);
        mdu_cmd.mplier = bounce_gain_q;
      end
      S_ALPHA: begin
        mdu_cmd.mag     = {24'd0, base_alpha_q};
        mdu_cmd.mplier  = fade_in ? used[15:0] : life_left_q;
        mdu_cmd.div_en  = 1'b1;
        mdu_cmd.div_sel = fade_in ? DIV_FADE_IN : DIV_MS;
      end
      default: begin
      end
    endcase
  end

  pmfs_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mdu_start),
    .cmd_i   (mdu_cmd),
    .done_o  (mdu_done),
    .res_o   (mdu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q[AX_X] <= '0;
      accel_q[AX_Y] <= '0;
      accel_q[AX_Z] <= '0;
      bounce_gain_q <= BOUNCE_GAIN_RST;
      life_total_q  <= LIFE_TOTAL_RST;
      base_alpha_q  <= BASE_ALPHA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACCEL_X:     accel_q[AX_X] <= $signed(cfg_data_i);
        REG_ACCEL_Y:     accel_q[AX_Y] <= $signed(cfg_data_i);
        REG_ACCEL_Z:     accel_q[AX_Z] <= $signed(cfg_data_i);
        REG_BOUNCE_GAIN: bounce_gain_q <= cfg_data_i[15:0];
        REG_LIFE_TOTAL:  life_total_q  <= cfg_data_i[15:0];
        REG_BASE_ALPHA:  base_alpha_q  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pos_q[AX_X]   <= '0;
      pos_q[AX_Y]   <= '0;
      pos_q[AX_Z]   <= '0;
      vel_q[AX_X]   <= '0;
      vel_q[AX_Y]   <= '0;
      vel_q[AX_Z]   <= '0;
      life_left_q   <= LIFE_TOTAL_RST;
      alive_q       <= 1'b1;
      last_time_q   <= '0;
      first_tick_q  <= 1'b1;
      dt_q          <= '0;
      now_q         <= '0;
      alpha_q       <= '0;
      ax_q          <= AX_X;
      launched_q    <= 1'b0;
      out_vld_q     <= 1'b0;
      out_pos_x_q   <= '0;
      out_pos_y_q   <= '0;
      out_pos_z_q   <= '0;
      out_alpha_q   <= '0;
      out_alive_q   <= 1'b0;
    end else begin
      if (result_o.ready && state_q != S_FIN) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (item_i.valid) begin
            if (item_i.kind == KIND_SPAWN) begin
              pos_q[AX_X]  <= item_i.start_pos_x;
              pos_q[AX_Y]  <= item_i.start_pos_y[WORD_W-1] ? '0 : item_i.start_pos_y;
              pos_q[AX_Z]  <= item_i.start_pos_z;
              vel_q[AX_X]  <= item_i.start_vel_x;
              vel_q[AX_Y]  <= item_i.start_vel_y;
              vel_q[AX_Z]  <= item_i.start_vel_z;
              life_left_q  <= life_total_q;
              alive_q      <= 1'b1;
              first_tick_q <= 1'b1;
              alpha_q      <= '0;
              state_q      <= S_FIN;
            end else if (!alive_q) begin
              alpha_q <= '0;
              state_q <= S_FIN;
            end else begin
              dt_q    <= dt_in;
              now_q   <= item_i.time_ms;
              ax_q    <= AX_X;
              state_q <= S_VEL;
            end
          end
        end
        S_VEL: begin
          if (mdu_done) begin
            vel_q[ax_q] <= sat_add(vel_q[ax_q], quot, accel_q[ax_q][WORD_W-1]);
            launched_q  <= 1'b0;
            state_q     <= S_POS;
          end else begin
            launched_q <= 1'b1;
          end
        end
        S_POS: begin
          if (mdu_done) begin
            pos_q[ax_q] <= sat_add(pos_q[ax_q], quot, vel_q[ax_q][WORD_W-1]);
            launched_q  <= 1'b0;
            if (ax_q == AX_Z) begin
              state_q <= pos_q[AX_Y][WORD_W-1] ? S_BNC : S_FADE;
            end else begin
              ax_q    <= ax_q + 2'd1;
              state_q <= S_VEL;
            end
          end else begin
            launched_q <= 1'b1;
          end
        end
        S_BNC: begin
          if (mdu_done) begin
            vel_q[AX_Y] <= vel_q[AX_Y][WORD_W-1] ? $signed(kept) : $signed(32'd0 - kept);
            pos_q[AX_Y] <= '0;
            launched_q  <= 1'b0;
            state_q     <= S_FADE;
          end else begin
            launched_q <= 1'b1;
          end
        end
        S_FADE: begin
          if (used_neg) begin
            alpha_q <= '0;
            state_q <= S_LIFE;
          end else if (fade_in || fade_out) begin
            state_q <= S_ALPHA;
          end else begin
            alpha_q <= base_alpha_q;
            state_q <= S_LIFE;
          end
        end
        S_ALPHA: begin
          if (mdu_done) begin
            alpha_q    <= mdu_res[7:0];
            launched_q <= 1'b0;
            state_q    <= S_LIFE;
          end else begin
            launched_q <= 1'b1;
          end
        end
        S_LIFE: begin
          life_left_q  <= life_next;
          alive_q      <= (life_next != '0);
          if (life_next == '0) begin
            alpha_q <= '0;
          end
          last_time_q  <= now_q;
          first_tick_q <= 1'b0;
          state_q      <= S_FIN;
        end
        S_FIN: begin
          if (!out_vld_q || result_o.ready) begin
            out_vld_q   <= 1'b1;
            out_pos_x_q <= pos_q[AX_X];
            out_pos_y_q <= pos_q[AX_Y];
            out_pos_z_q <= pos_q[AX_Z];
            out_alpha_q <= alpha_q;
            out_alive_q <= alive_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign item_i.ready   = (state_q == S_IDLE);
  assign result_o.valid = out_vld_q;
  assign result_o.pos_x = out_pos_x_q;
  assign result_o.pos_y = out_pos_y_q;
  assign result_o.pos_z = out_pos_z_q;
  assign result_o.alpha = out_alpha_q;
  assign result_o.alive = out_alive_q;

  a_pos_y_ground: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> !result_o.pos_y[WORD_W-1])
    else $error("result beat below ground");

  a_dead_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.alive) |-> result_o.alpha == '0)
    else $error("dead particle with nonzero alpha");

  a_done_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mdu_done |-> launched_q)
    else $error("muldiv result without a pending launch");

endmodule

`default_nettype wire

@@ test/particle_motion_fade_step_top_test.sv @@
// Self-checking bench for the particle motion and fade step block under random traffic.
module particle_motion_fade_step_top_test;
  import pmfs_pkg::*;

  localparam int unsigned ITEM_TARGET     = 1350;
  localparam int unsigned CALM_ITEMS      = 150;
  localparam int unsigned HOLD_OFF_CYCLES = 1500;
  localparam int unsigned WATCHDOG_LIMIT  = 8000;
  localparam int unsigned TAIL_CYCLES     = 600;
  localparam int unsigned REPORT_CAP      = 40;

  typedef struct packed {
    logic               kind;
    logic        [31:0] time_ms;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } spark_item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic        [7:0]  alpha;
    logic               alive;
  } spark_frame_t;

  class particle_scoreboard;
    logic signed [31:0] accel [3];
    logic        [15:0] gain;
    logic        [15:0] life_total;
    logic        [7:0]  full_alpha;
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic        [15:0] life_left;
    bit                 alive;
    bit                 first_tick;
    logic        [31:0] last_ms;
    spark_frame_t       frames_due [$];
    int unsigned        errors, beats, spawns, ticks, bounces, deaths, reg_writes;

    function new();
      foreach (accel[a]) begin
        accel[a] = '0;
        pos[a]   = '0;
        vel[a]   = '0;
      end
      gain       = BOUNCE_GAIN_RST;
      life_total = LIFE_TOTAL_RST;
      full_alpha = BASE_ALPHA_RST;
      life_left  = LIFE_TOTAL_RST;
      alive      = 1'b1;
      first_tick = 1'b1;
      last_ms    = '0;
      errors = 0; beats = 0; spawns = 0; ticks = 0;
      bounces = 0; deaths = 0; reg_writes = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      reg_writes++;
      case (idx)
        REG_ACCEL_X:     accel[0]   = data;
        REG_ACCEL_Y:     accel[1]   = data;
        REG_ACCEL_Z:     accel[2]   = data;
        REG_BOUNCE_GAIN: gain       = data[15:0];
        REG_LIFE_TOTAL:  life_total = data[15:0];
        REG_BASE_ALPHA:  full_alpha = data[7:0];
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint per_ms(longint v, longint dt);
      return (v * dt) / longint'(MS_PER_S);
    endfunction

    function logic [7:0] fade_level();
      longint used;
      used = longint'(life_total) - longint'(life_left);
      if (used < longint'(FADE_IN_MS)) begin
        if (used < 0) return 8'd0;
        return 8'((longint'(full_alpha) * used) / longint'(FADE_IN_MS));
      end
      if (longint'(life_left) < longint'(FADE_OUT_MS))
        return 8'((longint'(full_alpha) * longint'(life_left)) / longint'(FADE_OUT_MS));
      return full_alpha;
    endfunction

    function spark_frame_t predict_frame(spark_item_t it);
      spark_frame_t f;
      logic [31:0]  gap;
      longint       dt, v, kept;
      logic [7:0]   shade;
      int           a;
      shade = '0;
      if (it.kind == KIND_SPAWN) begin
        spawns++;
        pos[0] = it.sx;
        pos[1] = it.sy[31] ? '0 : it.sy;
        pos[2] = it.sz;
        vel[0] = it.vx;
        vel[1] = it.vy;
        vel[2] = it.vz;
        life_left  = life_total;
        alive      = 1'b1;
        first_tick = 1'b1;
        shade      = fade_level();
      end else if (alive) begin
        ticks++;
        dt = 0;
        if (!first_tick) begin
          gap = it.time_ms - last_ms;
          dt  = (gap > 32'hFFFF) ? 64'hFFFF : longint'(gap);
        end
        first_tick = 1'b0;
        for (a = 0; a < 3; a++) begin
          vel[a] = 32'(clip32(longint'(vel[a]) + per_ms(longint'(accel[a]), dt)));
          pos[a] = 32'(clip32(longint'(pos[a]) + per_ms(longint'(vel[a]), dt)));
        end
        if (pos[1] < 0) begin
          bounces++;
          v      = longint'(vel[1]);
          kept   = ((v < 0 ? -v : v) * longint'(gain)) >>> 16;
          vel[1] = 32'(v < 0 ? kept : -kept);
          pos[1] = '0;
        end
        shade     = fade_level();
        life_left = (longint'(life_left) > dt) ? 16'(longint'(life_left) - dt) : '0;
        if (life_left == 0) begin
          alive = 1'b0;
          deaths++;
        end
        last_ms = it.time_ms;
      end
      if (!alive) shade = '0;
      f.px    = pos[0];
      f.py    = pos[1];
      f.pz    = pos[2];
      f.alpha = shade;
      f.alive = alive;
      return f;
    endfunction

    function void note_item(spark_item_t it);
      frames_due.push_back(predict_frame(it));
    endfunction

    function void flag(string field, logic signed [31:0] want, logic signed [31:0] got);
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_frame(spark_frame_t got);
      spark_frame_t want;
      beats++;
      if (frames_due.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: result beat with no item waiting, expected none, actual pos_x %0d",
                   $time, got.px);
        return;
      end
      want = frames_due.pop_front();
      if (got.px !== want.px) flag("pos_x", want.px, got.px);
      if (got.py !== want.py) flag("pos_y", want.py, got.py);
      if (got.pz !== want.pz) flag("pos_z", want.pz, got.pz);
      if (got.alpha !== want.alpha) flag("alpha", want.alpha, got.alpha);
      if (got.alive !== want.alive) flag("alive", want.alive, got.alive);
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [WORD_W-1:0]    cfg_data_i;

  pmfs_in_if  item_if();
  pmfs_out_if result_if();

  particle_scoreboard board = new();
  int unsigned items_sent   = 0;
  bit          calm         = 1'b0;
  bit          src_idle_on  = 1'b0;
  bit          sink_idle_on = 1'b0;
  bit          hold_off_req = 1'b0;
  logic [31:0] now_ms       = '0;

  particle_motion_fade_step_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_if),
    .result_o   (result_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [31:0] spread(int unsigned units);
    return 32'(int'($urandom_range(0, 2 * units * 65536)) - int'(units * 65536));
  endfunction

  function automatic logic [31:0] pick_word(int unsigned units);
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom();
      default: return spread(units);
    endcase
  endfunction

  function automatic logic [31:0] pick_accel();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return ($urandom_range(0, 1) == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return spread(20);
    endcase
  endfunction

  function automatic logic [15:0] pick_life();
    case ($urandom_range(0, 9))
      0:          return 16'hFFFF;
      1:          return 16'($urandom());
      2, 3, 4, 5: return 16'($urandom_range(1, 400));
      default:    return 16'($urandom_range(400, 3000));
    endcase
  endfunction

  function automatic logic [31:0] next_step();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return $urandom();
      2, 3, 4: return $urandom_range(50, 1000);
      default: return $urandom_range(1, 50);
    endcase
  endfunction

  task automatic send_item(input spark_item_t it);
    if (src_idle_on && !calm && $urandom_range(0, 3) == 0) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.kind        <= it.kind;
    item_if.time_ms     <= it.time_ms;
    item_if.start_pos_x <= it.sx;
    item_if.start_pos_y <= it.sy;
    item_if.start_pos_z <= it.sz;
    item_if.start_vel_x <= it.vx;
    item_if.start_vel_y <= it.vy;
    item_if.start_vel_z <= it.vz;
    do @(posedge clk_i); while (!item_if.ready);
    board.note_item(it);
    items_sent++;
    calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
  endtask

  task automatic spawn(input logic [31:0] sx, sy, sz, vx, vy, vz);
    spark_item_t it;
    it.kind    = KIND_SPAWN;
    it.time_ms = $urandom();
    it.sx = sx; it.sy = sy; it.sz = sz;
    it.vx = vx; it.vy = vy; it.vz = vz;
    send_item(it);
  endtask

  task automatic tick(input logic [31:0] t);
    spark_item_t it;
    it.kind    = KIND_TICK;
    it.time_ms = t;
    it.sx = $urandom(); it.sy = $urandom(); it.sz = $urandom();
    it.vx = $urandom(); it.vy = $urandom(); it.vz = $urandom();
    send_item(it);
  endtask

  task automatic drain();
    item_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.frames_due.size() != 0);
  endtask

  task automatic apply_config(input logic [31:0] ax, ay, az,
                              input logic [15:0] g, lt, input logic [7:0] ba);
    logic [WORD_W-1:0]    vals [6];
    logic [CFG_IDX_W-1:0] idx  [6];
    int                   k;
    drain();
    vals = '{ax, ay, az, WORD_W'(g), WORD_W'(lt), WORD_W'(ba)};
    idx  = '{REG_ACCEL_X, REG_ACCEL_Y, REG_ACCEL_Z,
             REG_BOUNCE_GAIN, REG_LIFE_TOTAL, REG_BASE_ALPHA};
    for (k = 0; k < 6; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx[k];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
      board.set_reg(idx[k], vals[k]);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed_items();
    // first tick after reset, then a plain step on the reset particle
    tick(32'd123);
    tick(32'd423);
    // extremes, time wrap, backward time, death and a tick on the dead particle
    apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    spawn(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    tick(32'hFFFF_FFF0);
    tick(32'h0000_0010);
    tick(32'h0000_0005);
    tick(32'h0000_1234);
    // fall through the ground and bounce
    apply_config(32'h0, 32'hFFF6_3333, 32'h0, 16'd32768, 16'd1000, 8'd128);
    spawn(32'h0, 32'h000A_0000, 32'h0, 32'h0001_0000, 32'hFFEC_0000, 32'h0);
    tick(32'd0);
    tick(32'd1000);
    tick(32'd1500);
    // zero lifetime
    apply_config(32'h0, 32'h0, 32'h0, 16'd0, 16'd0, 8'd0);
    spawn(32'h5, 32'h5, 32'h5, 32'h0, 32'h0, 32'h0);
    tick(32'd77);
    // fade in, then fade out
    apply_config(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 16'hFFFF, 16'd300, 8'd200);
    spawn(32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    tick(32'd1000);
    tick(32'd1050);
    tick(32'd1100);
    tick(32'd1150);
    tick(32'd1200);
    // shrink the lifetime below the life left
    apply_config(32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 16'hFFFF, 16'd20, 8'd200);
    tick(32'd1230);
  endtask

  task automatic random_config(input int unsigned phase);
    if (phase == 0)
      apply_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
    else if (phase == 1)
      apply_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0, 16'h1, 8'h0);
    else
      apply_config(pick_accel(), pick_accel(), pick_accel(),
                   16'($urandom_range(0, 65535)), pick_life(), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input int unsigned span);
    int unsigned start, burst, k;
    start = items_sent;
    while (items_sent - start < span && items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 6) == 0) begin
        if ($urandom_range(0, 1) == 0) tick($urandom());
        else spawn($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        if ($urandom_range(0, 3) == 0) now_ms = $urandom();
        spawn(pick_word(1000), 32'(int'($urandom_range(0, 205 * 65536)) - 5 * 65536),
              pick_word(1000), pick_word(50), pick_word(50), pick_word(50));
        burst = $urandom_range(2, 12);
        for (k = 0; k < burst; k++) begin
          now_ms = now_ms + next_step();
          tick(now_ms);
        end
      end
    end
  endtask

  initial begin : result_side
    spark_frame_t got;
    int unsigned  stall;
    int unsigned  hold;
    stall = 0;
    hold  = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (result_if.valid && result_if.ready) begin
        got.px    = result_if.pos_x;
        got.py    = result_if.pos_y;
        got.pz    = result_if.pos_z;
        got.alpha = result_if.alpha;
        got.alive = result_if.alive;
        board.check_frame(got);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold         = HOLD_OFF_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        result_if.ready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        result_if.ready <= 1'b0;
      end else if (sink_idle_on && !calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11) - 1;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase;
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= REG_ACCEL_X;
    cfg_data_i          <= '0;
    item_if.valid       <= 1'b0;
    item_if.kind        <= KIND_TICK;
    item_if.time_ms     <= '0;
    item_if.start_pos_x <= '0;
    item_if.start_pos_y <= '0;
    item_if.start_pos_z <= '0;
    item_if.start_vel_x <= '0;
    item_if.start_vel_y <= '0;
    item_if.start_vel_z <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed_items();
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      random_config(phase);
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      // stall the result side long enough to back up the input
      if (phase == 3) hold_off_req = 1'b1;
      run_phase($urandom_range(40, 120));
      phase++;
    end
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Covered %0d spawns, %0d live ticks, %0d ground bounces, %0d deaths, %0d reg writes",
             board.spawns, board.ticks, board.bounces, board.deaths, board.reg_writes);
    $display("Checked %0d result beats for %0d items over %0d phases, %0d mismatches",
             board.beats, items_sent, phase, board.errors);
    if (board.errors == 0 && board.frames_due.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
